// ===== sv/hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsp_pkg
// shared codes, widths and lookup functions for the status line parser
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 10;
    localparam int ACC_W     = 11;
    localparam int OUTCOME_W = 2;
    localparam int SPACES_W  = 4;
    localparam int REASON_W  = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_ADDR_W = 1;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_OK      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAULT   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_PARSE   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_UNKNOWN = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WS_LIMIT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_REASON = 1'b1;

    localparam logic [SPACES_W-1:0] WS_LIMIT_RST   = 4'd5;
    localparam logic [REASON_W-1:0] MAX_REASON_RST = 8'd64;

    localparam logic [ACC_W-1:0] CODE_LIMIT     = 11'd1000;
    localparam logic [ACC_W-1:0] CODE_SATURATED = 11'd1001;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;

    // space, tab, lf, vt, ff, cr
    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    // table of the 58 registered status codes
    function automatic logic code_known(input logic [CODE_W-1:0] c);
        logic hit;
        unique case (c)
            10'd100, 10'd101, 10'd102,
            10'd200, 10'd201, 10'd202, 10'd203, 10'd204, 10'd205, 10'd206, 10'd207,
            10'd300, 10'd301, 10'd302, 10'd303, 10'd304, 10'd305, 10'd307, 10'd308,
            10'd400, 10'd401, 10'd402, 10'd403, 10'd404, 10'd405, 10'd406, 10'd407,
            10'd408, 10'd409, 10'd410, 10'd411, 10'd412, 10'd413, 10'd414, 10'd415,
            10'd416, 10'd417, 10'd421, 10'd422, 10'd423, 10'd424, 10'd425, 10'd426,
            10'd428, 10'd429, 10'd431, 10'd451,
            10'd500, 10'd502, 10'd503, 10'd504, 10'd505, 10'd506, 10'd507, 10'd508,
            10'd510, 10'd511, 10'd526:
                hit = 1'b1;
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== sv/http_status_line_parser.sv =====
// ----------------------------------------------------------------------------
// http_status_line_parser
// byte-wise parser for the code, spacing and reason phrase of a status line
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready | tdata: data_byte
//           |           |                   | tuser: stream_end, stream_fault
//  m_*      | out       | m_tvalid/m_tready | tdata: status_code
//           |           |                   | tuser: outcome
//  cfg_*    | in        | cfg_we            | cfg_addr 0 space limit, 1 reason limit
//
//  one word per cycle while results are taken: a word sits in the input register,
//  is parsed against the line state there and writes the result register
//  rst_n clears the line state, both valid flags and the limits to 5 and 64
//  a full result register that is not taken holds the parse stage; the input
//  register still takes one more word, then s_tready drops
//
module http_status_line_parser
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [1:0]                       s_tuser,   // [0] stream_end, [1] stream_fault

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [9:0] status_code, rest zero
    output logic [1:0]                       m_tuser,   // [1:0] outcome

    input  logic                             cfg_we,
    input  logic [hsp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [hsp_pkg::CFG_W-1:0]        cfg_wdata
);
    import hsp_pkg::*;

    // line phases
    localparam logic [1:0] PH_DIGITS = 2'd0;
    localparam logic [1:0] PH_SPACES = 2'd1;
    localparam logic [1:0] PH_REASON = 2'd2;

    // configuration
    logic [SPACES_W-1:0] ws_limit_reg;
    logic [REASON_W-1:0] max_reason_reg;

    // input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_end_reg;
    logic                in_fault_reg;

    // line state
    logic [1:0]          phase_reg,   phase_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic                seen_reg,    seen_next;
    logic [SPACES_W-1:0] spaces_reg,  spaces_next;
    logic [REASON_W-1:0] reason_reg,  reason_next;
    logic                cr_reg,      cr_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [OUTCOME_W-1:0] out_outcome_reg;
    logic [CODE_W-1:0]   out_code_reg;

    logic                out_free;
    logic                fire;
    logic                fin;
    logic [OUTCOME_W-1:0] fin_outcome;
    logic [CODE_W-1:0]   fin_code;

    logic                is_digit;
    logic [3:0]          digit_val;
    logic [13:0]         acc_mul;
    logic                to_spaces;
    logic                to_reason;
    logic [SPACES_W-1:0] spaces_inc;
    logic [REASON_W-1:0] reason_inc;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-CODE_W){1'b0}}, out_code_reg};
    assign m_tuser  = out_outcome_reg;

    assign is_digit   = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign digit_val  = 4'(in_byte_reg - CHAR_ZERO);
    // acc * 10 + digit, acc is at most 1001 here
    assign acc_mul    = ({3'b000, acc_reg} << 3) + ({3'b000, acc_reg} << 1)
                        + {10'd0, digit_val};
    assign spaces_inc = spaces_reg + 4'd1;
    assign reason_inc = reason_reg + 8'd1;

    // parse one word against the line state
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        spaces_next = spaces_reg;
        reason_next = reason_reg;
        cr_next     = cr_reg;
        fin         = 1'b0;
        fin_outcome = OUTCOME_OK;
        fin_code    = acc_reg[CODE_W-1:0];
        to_spaces   = 1'b0;
        to_reason   = 1'b0;

        if (in_fault_reg)
        begin
            fin         = 1'b1;
            fin_outcome = OUTCOME_FAULT;
            if (phase_reg != PH_SPACES && phase_reg != PH_REASON)
                fin_code = '0;
        end
        else
        begin
            // digits, the unused phase code behaves the same
            if (phase_reg != PH_SPACES && phase_reg != PH_REASON)
            begin
                if (!in_end_reg && is_digit)
                begin
                    if (acc_reg > CODE_LIMIT || acc_mul > {3'b000, CODE_LIMIT})
                        acc_next = CODE_SATURATED;
                    else
                        acc_next = acc_mul[ACC_W-1:0];
                    seen_next = 1'b1;
                end
                else if (!seen_reg || acc_reg > CODE_LIMIT)
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_PARSE;
                    fin_code    = '0;
                end
                else if (!code_known(acc_reg[CODE_W-1:0]))
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_UNKNOWN;
                end
                else
                begin
                    to_spaces = 1'b1;
                end
            end

            // whitespace between code and reason
            if (phase_reg == PH_SPACES || to_spaces)
            begin
                if (spaces_reg >= ws_limit_reg)
                begin
                    if (spaces_reg == '0)
                    begin
                        fin         = 1'b1;
                        fin_outcome = OUTCOME_PARSE;
                    end
                    else
                        to_reason = 1'b1;
                end
                else if (in_end_reg)
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_PARSE;
                end
                else if (is_ws(in_byte_reg))
                begin
                    spaces_next = spaces_inc;
                    phase_next  = PH_SPACES;
                    if (spaces_inc >= ws_limit_reg)
                    begin
                        phase_next = PH_REASON;
                        if (reason_reg >= max_reason_reg)
                        begin
                            fin         = 1'b1;
                            fin_outcome = OUTCOME_PARSE;
                        end
                    end
                end
                else if (spaces_reg == '0)
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_PARSE;
                end
                else
                    to_reason = 1'b1;
            end

            // reason phrase up to cr lf
            if (phase_reg == PH_REASON || to_reason)
            begin
                if (reason_reg >= max_reason_reg || in_end_reg)
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_PARSE;
                end
                else if (in_byte_reg == CHAR_LF && cr_reg)
                begin
                    fin         = 1'b1;
                    fin_outcome = OUTCOME_OK;
                end
                else
                begin
                    phase_next  = PH_REASON;
                    cr_next     = (in_byte_reg == CHAR_CR);
                    reason_next = reason_inc;
                    if (reason_inc >= max_reason_reg)
                    begin
                        fin         = 1'b1;
                        fin_outcome = OUTCOME_PARSE;
                    end
                end
            end
        end

        // a finished line rearms the parser
        if (fin)
        begin
            phase_next  = PH_DIGITS;
            acc_next    = '0;
            seen_next   = 1'b0;
            spaces_next = '0;
            reason_next = '0;
            cr_next     = 1'b0;
        end
    end

    assign out_valid_next = fire ? fin : (out_valid_reg && !m_tready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_limit_reg   <= WS_LIMIT_RST;
            max_reason_reg <= MAX_REASON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WS_LIMIT:   ws_limit_reg   <= cfg_wdata[SPACES_W-1:0];
                REG_MAX_REASON: max_reason_reg <= cfg_wdata[REASON_W-1:0];
                default:        ws_limit_reg   <= ws_limit_reg;
            endcase
        end
    end

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_DIGITS;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            spaces_reg    <= '0;
            reason_reg    <= '0;
            cr_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                spaces_reg <= spaces_next;
                reason_reg <= reason_next;
                cr_reg     <= cr_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_end_reg   <= s_tuser[0];
            in_fault_reg <= s_tuser[1];
        end
        if (fire && fin)
        begin
            out_outcome_reg <= fin_outcome;
            out_code_reg    <= fin_code;
        end
    end

    // accumulator never passes the saturation value
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= CODE_SATURATED)
        else $error("code accumulator out of range");

    // past the digits phase a digit has been seen
    a_seen_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SPACES || phase_reg == PH_REASON) |-> seen_reg)
        else $error("left digits phase without a digit");

    // a faulting word always produces a result
    a_fault_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_fault_reg) |=> (out_valid_reg && out_outcome_reg == OUTCOME_FAULT))
        else $error("fault word gave no fault result");

    // a result rearms the line state
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && fin) |=> (phase_reg == PH_DIGITS && acc_reg == '0 && !seen_reg))
        else $error("parser not rearmed after result");

    // a good line carries a known code
    a_ok_known: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_outcome_reg == OUTCOME_OK) |-> code_known(out_code_reg))
        else $error("ok result with unknown code");

endmodule
